// ===== rtl/vmmac_pkg.sv =====
// Shared constants and types for the modular multiply-add checksum block.
package vmmac_pkg;

  localparam int unsigned WORD_WIDTH_DEF = 32;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned ADDR_W         = 4;
  localparam int unsigned MODULUS_FLOOR  = 2;

  localparam logic [1:0] REG_MODULUS    = 2'd0;
  localparam logic [1:0] REG_MULTIPLIER = 2'd1;
  localparam logic [1:0] REG_INCREMENT  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/vector_modular_mul_add_checksum.sv =====
// Digit-serial modular multiply-add of a word stream with a per-vector XOR checksum.
//
// Each item on the input channel (element_i, is_last_i) produces one item on the
// output channel: reduced_o = (element * multiplier + increment) mod modulus, and
// running_xor_o = XOR of all reduced values of the vector so far. end_of_vector_o
// copies is_last_i; the checksum clears as that item's output is registered.
// The modulus, multiplier and increment registers sit on the APB port at byte
// addresses 0, 4 and 8. A modulus written below two is stored as two.
// The work is done on one item at a time. A two-bit-per-cycle shift-add
// multiplier forms the full product plus increment, and a radix-4 restoring
// remainder unit then takes two dividend bits per cycle. The result is written
// to the output register from the done state, and a new item is taken in the
// idle state that follows.
// The output register holds a finished result while the receiver stalls, and
// the next item is accepted and worked on meanwhile; it waits before its own
// result is written until that register is free.
// Reset clears the checksum and restores the registers to modulus 2,
// multiplier 1 and increment 0.
module vector_modular_mul_add_checksum
  import vmmac_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       element_i,
  input  logic              is_last_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       reduced_o,
  output logic [31:0]       running_xor_o,
  output logic              end_of_vector_o
);

  localparam int unsigned W         = WORD_WIDTH;
  localparam int unsigned DIG_STEPS = (W + 1) / 2;
  localparam int unsigned LO_W      = 2 * DIG_STEPS;
  localparam int unsigned SH_W      = 2 * LO_W;
  localparam int unsigned CNT_W     = $clog2(LO_W);

  logic [W-1:0]       modulus_q, multiplier_q, increment_q;
  logic [W-1:0]       wr_value;
  logic [1:0]         reg_idx;
  logic               cfg_write;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [SH_W-1:0]    shreg_q;
  logic [W+1:0]       mult3_q, mod3_q;
  logic [W-1:0]       rem_q;
  logic               last_q;
  logic [W-1:0]       xor_acc_q;
  logic               out_valid_q;

  logic               accept;
  logic               load_out;
  logic               cnt_zero;
  logic [LO_W+1:0]    addend;
  logic [LO_W+1:0]    mul_sum;
  logic [W+1:0]       rr;
  logic [W+2:0]       diff1, diff2, diff3;
  logic [W-1:0]       rem_next;
  logic [W-1:0]       new_xor;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;
  assign wr_value  = pwdata[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    <= W'(MODULUS_FLOOR);
      multiplier_q <= W'(1);
      increment_q  <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_MODULUS: begin
          modulus_q <= (wr_value < W'(MODULUS_FLOOR)) ? W'(MODULUS_FLOOR) : wr_value;
        end
        REG_MULTIPLIER: begin
          multiplier_q <= wr_value;
        end
        REG_INCREMENT: begin
          increment_q <= wr_value;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODULUS:    prdata = DATA_W'(modulus_q);
      REG_MULTIPLIER: prdata = DATA_W'(multiplier_q);
      REG_INCREMENT:  prdata = DATA_W'(increment_q);
      default:        prdata = '0;
    endcase
  end

  // Sequencer.
  assign cnt_zero = (cnt_q == '0);
  assign accept   = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_zero) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_zero) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_DONE: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= CNT_W'(DIG_STEPS - 1);
      end else if (state_q == ST_MUL && cnt_zero) begin
        cnt_q <= CNT_W'(LO_W - 1);
      end else if ((state_q == ST_MUL || state_q == ST_DIV) && !cnt_zero) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Multiply step: add one two-bit digit of the element times the multiplier.
  always_comb begin
    case (shreg_q[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = (LO_W + 2)'(multiplier_q);
      2'd2:    addend = (LO_W + 2)'({multiplier_q, 1'b0});
      2'd3:    addend = (LO_W + 2)'(mult3_q);
      default: addend = '0;
    endcase
  end

  assign mul_sum = (LO_W + 2)'(shreg_q[SH_W-1:LO_W]) + addend;

  // Remainder step: bring in two dividend bits and subtract the largest fitting multiple.
  assign rr    = {rem_q, shreg_q[SH_W-1 -: 2]};
  assign diff1 = {1'b0, rr} - (W + 3)'(modulus_q);
  assign diff2 = {1'b0, rr} - (W + 3)'({modulus_q, 1'b0});
  assign diff3 = {1'b0, rr} - {1'b0, mod3_q};

  always_comb begin
    if (!diff3[W+2]) begin
      rem_next = diff3[W-1:0];
    end else if (!diff2[W+2]) begin
      rem_next = diff2[W-1:0];
    end else if (!diff1[W+2]) begin
      rem_next = diff1[W-1:0];
    end else begin
      rem_next = rr[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      shreg_q <= {LO_W'(increment_q), LO_W'(element_i[W-1:0])};
      mult3_q <= (W + 2)'(multiplier_q) + (W + 2)'({multiplier_q, 1'b0});
      mod3_q  <= (W + 2)'(modulus_q) + (W + 2)'({modulus_q, 1'b0});
      rem_q   <= '0;
      last_q  <= is_last_i;
    end else if (state_q == ST_MUL) begin
      shreg_q <= {mul_sum, shreg_q[LO_W-1:2]};
    end else if (state_q == ST_DIV) begin
      shreg_q <= {shreg_q[SH_W-3:0], 2'b00};
      rem_q   <= rem_next;
    end
  end

  // Output register and checksum.
  assign new_xor = xor_acc_q ^ rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      xor_acc_q   <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        xor_acc_q   <= last_q ? '0 : new_xor;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      reduced_o       <= 32'(rem_q);
      running_xor_o   <= 32'(new_xor);
      end_of_vector_o <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The modulus register never holds a value below the floor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    modulus_q >= W'(MODULUS_FLOOR))
    else $error("modulus register below floor");

  // Taking the item that ends a vector, with no new result loaded behind it,
  // leaves the checksum cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && end_of_vector_o && !load_out |=> xor_acc_q == '0)
    else $error("checksum not cleared after end of vector");

  // An accepted item starts the multiply phase with a full digit count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_MUL && cnt_q == CNT_W'(DIG_STEPS - 1))
    else $error("multiply phase not started after accept");

endmodule
